/* hdl/u2cal_pkg.sv */
// Shared constants and the month-start table for the seconds-to-calendar pipeline.
package u2cal_pkg;

   // Input window that gives a year of 2000..2099 (2000-01-01 to 2100-01-01).
   localparam logic [39:0] SEC_LO = 40'd946684800;
   localparam logic [39:0] SEC_HI = 40'd4102444800;

   // Days since the epoch: (secs >> 7) / 675, since 86400 = 128 * 675.
   localparam int unsigned DAY_DIV      = 675;
   localparam logic [22:0] DAY_RECIP    = 23'd6362914;  // floor(2^32 / 675)

   // Day count of 1996-03-01, start of a four-year cycle with its leap day last.
   localparam logic [15:0] CYCLE_BASE   = 16'd9556;
   localparam logic [10:0] CYCLE_DAYS   = 11'd1461;
   localparam logic [19:0] CYCLE_RECIP  = 20'd734937;  // ceil(2^30 / 1461)
   localparam logic [10:0] YEAR_DAYS    = 11'd365;

   localparam logic [16:0] WEEK_RECIP   = 17'd74899;   // ceil(2^19 / 7)
   localparam logic [17:0] SIXTY_RECIP  = 18'd139811;  // ceil(2^23 / 60)
   localparam logic [12:0] MONTH_RECIP  = 13'd6854;    // ceil(2^20 / 153)

   localparam logic [6:0]  YEAR_OFFSET  = 7'd96;       // 1996 - 1900

   // First day of each March-based month within the year: (153 * mp + 2) / 5.
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] s;
      case (mp)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd61;
         4'd3:    s = 9'd92;
         4'd4:    s = 9'd122;
         4'd5:    s = 9'd153;
         4'd6:    s = 9'd184;
         4'd7:    s = 9'd214;
         4'd8:    s = 9'd245;
         4'd9:    s = 9'd275;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd337;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

endpackage

/* hdl/unix_seconds_to_calendar_core.sv */
// Top level: eight-stage pipeline from Unix seconds to UTC calendar fields.
// Throughput: one transaction per cycle; each stage holds when its successor is full and
// stalled, so bubbles are squeezed out and a stall loses nothing.
// The stage depth is set by the reciprocal multiplies for /675, /1461, /60, /7 and /153.
// Reset (synchronous, active high) clears the stage valid bits only.
module unix_seconds_to_calendar_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [39:0] unix_seconds (signed)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] year_since_1900, [11:8] month_index,
                                    // [16:12] day_of_month, [21:17] hour_of_day,
                                    // [27:22] minute_of_hour, [33:28] second_of_minute,
                                    // [36:34] day_of_week, [39:37] zero
   output logic        rsp_tuser    // [0] valid_res
);

   localparam int unsigned NSTG = 8;

   // Stage valid bits and per-stage load enables. A stage loads when it is empty
   // or when the stage after it is moving on.
   logic [NSTG-1:0] vld_ff, vld_in, en;

   always_comb begin
      en[NSTG-1] = !vld_ff[NSTG-1] || rsp_tready;
      for (int i = NSTG - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[0] = en[0] ? req_tvalid : vld_ff[0];
      for (int i = 1; i < NSTG; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = vld_ff[NSTG-1];

   // ---------------------------------------------------------------------------
   // Stage 1: range check and first reciprocal multiply for the day number.
   // Only inputs below 2^32 can be in range, so the divide works on 32 bits.
   // ---------------------------------------------------------------------------
   logic        ok1_ff, ok1_in;
   logic [24:0] x1_ff;
   logic [6:0]  lo1_ff;
   logic [15:0] qe1_ff, qe1_in;
   logic [47:0] prod1;

   always_comb begin
      ok1_in = !req_tdata[39] && (req_tdata >= u2cal_pkg::SEC_LO)
               && (req_tdata < u2cal_pkg::SEC_HI);
      prod1  = {23'd0, req_tdata[31:7]} * {25'd0, u2cal_pkg::DAY_RECIP};
      qe1_in = prod1[47:32];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         ok1_ff <= ok1_in;
         x1_ff  <= req_tdata[31:7];
         lo1_ff <= req_tdata[6:0];
         qe1_ff <= qe1_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: remainder of the estimate; it can be one divisor too large.
   // ---------------------------------------------------------------------------
   logic        ok2_ff;
   logic [6:0]  lo2_ff;
   logic [15:0] qe2_ff;
   logic [10:0] r2_ff, r2_in;

   assign r2_in = 11'(x1_ff - 25'(qe1_ff) * 25'(u2cal_pkg::DAY_DIV));

   always_ff @(posedge clock) begin
      if (en[1]) begin
         ok2_ff <= ok1_ff;
         lo2_ff <= lo1_ff;
         qe2_ff <= qe1_ff;
         r2_ff  <= r2_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 3: correct the quotient, form second of day, cycle offset, weekday base.
   // ---------------------------------------------------------------------------
   logic        ok3_ff;
   logic [16:0] sod3_ff, sod3_in;
   logic [15:0] u3_ff, u3_in;
   logic [15:0] d43_ff, d43_in;
   logic        fix3;
   logic [15:0] days3;
   logic [9:0]  rd3;

   always_comb begin
      fix3   = (r2_ff >= 11'(u2cal_pkg::DAY_DIV));
      days3  = qe2_ff + 16'(fix3);
      rd3    = fix3 ? 10'(r2_ff - 11'(u2cal_pkg::DAY_DIV)) : r2_ff[9:0];
      sod3_in = {rd3, lo2_ff};
      u3_in  = days3 - u2cal_pkg::CYCLE_BASE;
      d43_in = days3 + 16'd4;   // the epoch day was a Thursday
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         ok3_ff  <= ok2_ff;
         sod3_ff <= sod3_in;
         u3_ff   <= u3_in;
         d43_ff  <= d43_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 4: reciprocal multiplies for cycle number, weeks and total minutes.
   // ---------------------------------------------------------------------------
   logic        ok4_ff;
   logic [16:0] sod4_ff;
   logic [15:0] u4_ff, d44_ff;
   logic [4:0]  c4_ff, c4_in;
   logic [12:0] q74_ff, q74_in;
   logic [10:0] mt4_ff, mt4_in;
   logic [35:0] pc4;
   logic [32:0] pw4;
   logic [34:0] pm4;

   always_comb begin
      pc4    = {20'd0, u3_ff} * {16'd0, u2cal_pkg::CYCLE_RECIP};
      pw4    = {17'd0, d43_ff} * {16'd0, u2cal_pkg::WEEK_RECIP};
      pm4    = {18'd0, sod3_ff} * {17'd0, u2cal_pkg::SIXTY_RECIP};
      c4_in  = pc4[34:30];
      q74_in = pw4[31:19];
      mt4_in = pm4[33:23];
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         ok4_ff  <= ok3_ff;
         sod4_ff <= sod3_ff;
         u4_ff   <= u3_ff;
         d44_ff  <= d43_ff;
         c4_ff   <= c4_in;
         q74_ff  <= q74_in;
         mt4_ff  <= mt4_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 5: day in cycle, weekday, second, hour.
   // ---------------------------------------------------------------------------
   logic        ok5_ff;
   logic [4:0]  c5_ff;
   logic [10:0] r5_ff, r5_in;
   logic [2:0]  wd5_ff, wd5_in;
   logic [5:0]  sec5_ff, sec5_in;
   logic [10:0] mt5_ff;
   logic [4:0]  hr5_ff, hr5_in;
   logic [28:0] ph5;

   always_comb begin
      r5_in   = 11'(u4_ff - 16'(c4_ff) * 16'(u2cal_pkg::CYCLE_DAYS));
      wd5_in  = 3'(d44_ff - 16'(q74_ff) * 16'd7);
      sec5_in = 6'(sod4_ff - 17'(mt4_ff) * 17'd60);
      ph5     = {18'd0, mt4_ff} * {11'd0, u2cal_pkg::SIXTY_RECIP};
      hr5_in  = ph5[27:23];
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         ok5_ff  <= ok4_ff;
         c5_ff   <= c4_ff;
         r5_ff   <= r5_in;
         wd5_ff  <= wd5_in;
         sec5_ff <= sec5_in;
         mt5_ff  <= mt4_ff;
         hr5_ff  <= hr5_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 6: year within cycle by compare, day of March-based year, minute.
   // ---------------------------------------------------------------------------
   logic        ok6_ff;
   logic [8:0]  doy6_ff, doy6_in;
   logic [6:0]  yp6_ff, yp6_in;
   logic [2:0]  wd6_ff;
   logic [5:0]  sec6_ff, min6_ff, min6_in;
   logic [4:0]  hr6_ff;
   logic [1:0]  yc6;

   always_comb begin
      yc6 = 2'(r5_ff >= u2cal_pkg::YEAR_DAYS)
          + 2'(r5_ff >= 11'(2 * 365))
          + 2'(r5_ff >= 11'(3 * 365));
      doy6_in = 9'(r5_ff - 11'(yc6) * u2cal_pkg::YEAR_DAYS);
      yp6_in  = {c5_ff, 2'b00} + 7'(yc6);
      min6_in = 6'(mt5_ff - 11'(hr5_ff) * 11'd60);
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         ok6_ff  <= ok5_ff;
         doy6_ff <= doy6_in;
         yp6_ff  <= yp6_in;
         wd6_ff  <= wd5_ff;
         sec6_ff <= sec5_ff;
         min6_ff <= min6_in;
         hr6_ff  <= hr5_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 7: March-based month number, (5 * doy + 2) / 153.
   // ---------------------------------------------------------------------------
   logic        ok7_ff;
   logic [8:0]  doy7_ff;
   logic [6:0]  yp7_ff;
   logic [3:0]  mp7_ff, mp7_in;
   logic [2:0]  wd7_ff;
   logic [5:0]  sec7_ff, min7_ff;
   logic [4:0]  hr7_ff;
   logic [10:0] x7;
   logic [23:0] pm7;

   always_comb begin
      x7     = 11'(doy6_ff) * 11'd5 + 11'd2;
      pm7    = {13'd0, x7} * {11'd0, u2cal_pkg::MONTH_RECIP};
      mp7_in = pm7[23:20];
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         ok7_ff  <= ok6_ff;
         doy7_ff <= doy6_ff;
         yp7_ff  <= yp6_ff;
         mp7_ff  <= mp7_in;
         wd7_ff  <= wd6_ff;
         sec7_ff <= sec6_ff;
         min7_ff <= min6_ff;
         hr7_ff  <= hr6_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 8 (output register): day, month, year; zero every field when out of range.
   // January and February belong to the next calendar year.
   // ---------------------------------------------------------------------------
   logic        ok8_ff;
   logic [7:0]  yr8_ff, yr8_in;
   logic [3:0]  mo8_ff, mo8_in;
   logic [4:0]  dm8_ff, dm8_in;
   logic [4:0]  hr8_ff, hr8_in;
   logic [5:0]  min8_ff, min8_in, sec8_ff, sec8_in;
   logic [2:0]  wd8_ff, wd8_in;
   logic        late8;

   always_comb begin
      late8  = (mp7_ff >= 4'd10);
      yr8_in = 8'(u2cal_pkg::YEAR_OFFSET) + 8'(yp7_ff) + 8'(late8);
      mo8_in = late8 ? 4'(mp7_ff - 4'd10) : 4'(mp7_ff + 4'd2);
      dm8_in = 5'(doy7_ff - u2cal_pkg::month_start(mp7_ff) + 9'd1);
      hr8_in  = hr7_ff;
      min8_in = min7_ff;
      sec8_in = sec7_ff;
      wd8_in  = wd7_ff;
      if (!ok7_ff) begin
         yr8_in  = '0;
         mo8_in  = '0;
         dm8_in  = '0;
         hr8_in  = '0;
         min8_in = '0;
         sec8_in = '0;
         wd8_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         ok8_ff  <= ok7_ff;
         yr8_ff  <= yr8_in;
         mo8_ff  <= mo8_in;
         dm8_ff  <= dm8_in;
         hr8_ff  <= hr8_in;
         min8_ff <= min8_in;
         sec8_ff <= sec8_in;
         wd8_ff  <= wd8_in;
      end
   end

   assign rsp_tuser = ok8_ff;
   assign rsp_tdata = {3'd0, wd8_ff, sec8_ff, min8_ff, hr8_ff, dm8_ff, mo8_ff, yr8_ff};

endmodule
